### src/imq_pkg.sv
// Shared types and codes for the indexed min priority queue.
package imq_pkg;

   localparam logic [1:0] OP_INSERT  = 2'd0;
   localparam logic [1:0] OP_CHANGE  = 2'd1;
   localparam logic [1:0] OP_EXTRACT = 2'd2;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_EMPTY   = 2'd1;
   localparam logic [1:0] ST_QUEUED  = 2'd2;
   localparam logic [1:0] ST_ABSENT  = 2'd3;

   typedef struct packed {
      logic [7:0]         key;
      logic signed [31:0] prio;
   } entry_type;

endpackage

### src/imq_heap_mem.sv
// Heap slot store: one write port and two registered read ports.
module imq_heap_mem #(
   parameter int SLOTS = 256,
   parameter int SW    = 8
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [SW-1:0]       wr_addr,
   input  imq_pkg::entry_type  wr_data,
   input  logic [SW-1:0]       rda_addr,
   input  logic [SW-1:0]       rdb_addr,
   output imq_pkg::entry_type  rda_data,
   output imq_pkg::entry_type  rdb_data
);

   imq_pkg::entry_type mem [SLOTS];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rda_data <= mem[rda_addr];
      rdb_data <= mem[rdb_addr];
   end

endmodule

### src/imq_pos_mem.sv
// Key position store: heap slot of each key, registered read.
module imq_pos_mem #(
   parameter int KEYS = 256,
   parameter int KW   = 8,
   parameter int SW   = 8
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [KW-1:0] wr_addr,
   input  logic [SW-1:0] wr_data,
   input  logic [KW-1:0] rd_addr,
   output logic [SW-1:0] rd_data
);

   logic [SW-1:0] mem [KEYS];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

### src/indexed_min_priority_queue.sv
// Top level: indexed binary min-heap sequencer over slot and position memories.
//
// Each request beat carries an opcode (insert, change priority, extract minimum), a key
// and a signed Q16.16 priority; exactly one response beat follows per request. Items are
// handled one at a time: a request is taken only while no response is pending and the
// sequencer is idle. Each heap level walked (at most 8 for 256 keys) is one read of the
// slot memory followed by one compare-and-write step. Change first reads the key
// position and old priority, extract first reads the root and last slot. The key
// space is min(NUM_KEYS, 256); presence flags are flip-flops cleared by reset.
module indexed_min_priority_queue #(
   parameter int NUM_KEYS = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [1:0] opcode, [9:2] key, [41:10] priority_req, [47:42] zero
   input  logic [47:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [1:0] status, [9:2] min_key, [41:10] min_priority, [42] key_was_queued,
   // [51:43] queue_count, [55:52] zero
   output logic [55:0] rsp_tdata
);

   localparam int KEYS = (NUM_KEYS < 256) ? NUM_KEYS : 256;
   localparam int KW   = $clog2(KEYS);
   localparam int SW   = $clog2(KEYS);
   localparam int CW   = $clog2(KEYS + 1);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_POS  = 4'd1;
   localparam logic [3:0] S_OLD  = 4'd2;
   localparam logic [3:0] S_OLDC = 4'd3;
   localparam logic [3:0] S_EXT  = 4'd4;
   localparam logic [3:0] S_EXTC = 4'd5;
   localparam logic [3:0] S_UP   = 4'd6;
   localparam logic [3:0] S_UPC  = 4'd7;
   localparam logic [3:0] S_DN   = 4'd8;
   localparam logic [3:0] S_DNC  = 4'd9;

   logic [3:0]         state_ff, state_in;
   logic [1:0]         op_ff, op_in;
   logic [7:0]         key_ff, key_in;
   imq_pkg::entry_type cur_ff, cur_in;
   logic [SW-1:0]      slot_ff, slot_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [KEYS-1:0]    present_ff, present_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         status_ff, status_in;
   logic [7:0]         mkey_ff, mkey_in;
   logic [31:0]        mprio_ff, mprio_in;
   logic               was_ff, was_in;

   logic               hw_en;
   logic [SW-1:0]      hw_addr, hra_addr, hrb_addr;
   imq_pkg::entry_type hw_data, hra_data, hrb_data;
   logic               pw_en;
   logic [KW-1:0]      pw_addr;
   logic [SW-1:0]      pw_data, pr_data;

   logic [1:0]         r_op;
   logic [7:0]         r_key;
   logic signed [31:0] r_prio;
   logic [KW-1:0]      r_idx;
   logic               r_space, r_was, accept;
   logic [CW:0]        child_l, child_r;
   logic [SW-1:0]      parent;
   logic               right_ok, pick_r;
   imq_pkg::entry_type child;
   logic [SW-1:0]      child_slot;

   assign r_op    = req_tdata[1:0];
   assign r_key   = req_tdata[9:2];
   assign r_prio  = req_tdata[41:10];
   assign r_idx   = KW'(r_key);
   assign r_space = 9'(r_key) < 9'(KEYS);
   assign r_was   = r_space && present_ff[r_idx];
   assign accept  = req_tvalid && req_tready;

   assign req_tready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, 9'(count_ff), was_ff, mprio_ff, mkey_ff, status_ff};

   assign child_l  = ((CW + 1)'(slot_ff) << 1) + (CW + 1)'(1);
   assign child_r  = child_l + (CW + 1)'(1);
   assign parent   = (slot_ff - SW'(1)) >> 1;
   assign right_ok = child_r < (CW + 1)'(count_ff);
   assign pick_r   = right_ok && (hrb_data.prio < hra_data.prio);
   assign child    = pick_r ? hrb_data : hra_data;
   assign child_slot = pick_r ? SW'(child_r) : SW'(child_l);

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      cur_in       = cur_ff;
      slot_in      = slot_ff;
      count_in     = count_ff;
      present_in   = present_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      status_in    = status_ff;
      mkey_in      = mkey_ff;
      mprio_in     = mprio_ff;
      was_in       = was_ff;
      hw_en        = 1'b0;
      hw_addr      = slot_ff;
      hw_data      = cur_ff;
      hra_addr     = SW'(child_l);
      hrb_addr     = SW'(child_r);
      pw_en        = 1'b0;
      pw_addr      = KW'(cur_ff.key);
      pw_data      = slot_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in     = r_op;
               key_in    = r_key;
               cur_in    = '{key: r_key, prio: r_prio};
               was_in    = r_was;
               status_in = imq_pkg::ST_OK;
               mkey_in   = '0;
               mprio_in  = '0;
               if (r_op == imq_pkg::OP_INSERT) begin
                  if (!r_space) begin
                     status_in    = imq_pkg::ST_ABSENT;
                     rsp_valid_in = 1'b1;
                  end else if (r_was) begin
                     status_in    = imq_pkg::ST_QUEUED;
                     rsp_valid_in = 1'b1;
                  end else begin
                     slot_in           = SW'(count_ff);
                     count_in          = count_ff + CW'(1);
                     present_in[r_idx] = 1'b1;
                     state_in          = S_UP;
                  end
               end else if (r_op == imq_pkg::OP_CHANGE) begin
                  if (!r_was) begin
                     status_in    = imq_pkg::ST_ABSENT;
                     rsp_valid_in = 1'b1;
                  end else begin
                     state_in = S_POS;
                  end
               end else if (r_op == imq_pkg::OP_EXTRACT) begin
                  if (count_ff == '0) begin
                     status_in    = imq_pkg::ST_EMPTY;
                     rsp_valid_in = 1'b1;
                  end else begin
                     state_in = S_EXT;
                  end
               end else begin
                  rsp_valid_in = 1'b1;
               end
            end
         end
         S_POS: begin
            state_in = S_OLD;
         end
         S_OLD: begin
            slot_in  = pr_data;
            hra_addr = pr_data;
            state_in = S_OLDC;
         end
         S_OLDC: begin
            state_in = (cur_ff.prio > hra_data.prio) ? S_DN : S_UP;
         end
         S_EXT: begin
            hra_addr = '0;
            hrb_addr = SW'(count_ff - CW'(1));
            state_in = S_EXTC;
         end
         S_EXTC: begin
            mkey_in  = hra_data.key;
            mprio_in = hra_data.prio;
            present_in[KW'(hra_data.key)] = 1'b0;
            count_in = count_ff - CW'(1);
            cur_in   = hrb_data;
            slot_in  = '0;
            if (count_ff == CW'(1)) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else begin
               state_in = S_DN;
            end
         end
         S_UP: begin
            hra_addr = parent;
            if (slot_ff == '0) begin
               hw_en        = 1'b1;
               pw_en        = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else begin
               state_in = S_UPC;
            end
         end
         S_UPC: begin
            if (cur_ff.prio < hra_data.prio) begin
               hw_en    = 1'b1;
               hw_data  = hra_data;
               pw_en    = 1'b1;
               pw_addr  = KW'(hra_data.key);
               slot_in  = parent;
               state_in = S_UP;
            end else begin
               hw_en        = 1'b1;
               pw_en        = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_DN: begin
            if (child_l >= (CW + 1)'(count_ff)) begin
               hw_en        = 1'b1;
               pw_en        = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else begin
               state_in = S_DNC;
            end
         end
         S_DNC: begin
            if (child.prio < cur_ff.prio) begin
               hw_en    = 1'b1;
               hw_data  = child;
               pw_en    = 1'b1;
               pw_addr  = KW'(child.key);
               slot_in  = child_slot;
               state_in = S_DN;
            end else begin
               hw_en        = 1'b1;
               pw_en        = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         present_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         present_ff   <= present_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff     <= op_in;
      key_ff    <= key_in;
      cur_ff    <= cur_in;
      slot_ff   <= slot_in;
      status_ff <= status_in;
      mkey_ff   <= mkey_in;
      mprio_ff  <= mprio_in;
      was_ff    <= was_in;
   end

   imq_heap_mem #(
      .SLOTS (KEYS),
      .SW    (SW)
   ) u_heap (
      .clock    (clock),
      .wr_en    (hw_en),
      .wr_addr  (hw_addr),
      .wr_data  (hw_data),
      .rda_addr (hra_addr),
      .rdb_addr (hrb_addr),
      .rda_data (hra_data),
      .rdb_data (hrb_data)
   );

   imq_pos_mem #(
      .KEYS (KEYS),
      .KW   (KW),
      .SW   (SW)
   ) u_pos (
      .clock   (clock),
      .wr_en   (pw_en),
      .wr_addr (pw_addr),
      .wr_data (pw_data),
      .rd_addr (KW'(key_ff)),
      .rd_data (pr_data)
   );

`ifndef ASSERT_OFF
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      (CW + 1)'(count_ff) <= (CW + 1)'(KEYS))
      else $error("queue count beyond key space");
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_tready)
      else $error("request taken while an item is in flight");
   a_no_take_pending: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !rsp_valid_ff)
      else $error("request ready with a response pending");
   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && status_ff == imq_pkg::ST_EMPTY) |-> (count_ff == '0))
      else $error("empty status with queued keys");
   a_op_change_prio: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_POS) |-> (op_ff == imq_pkg::OP_CHANGE))
      else $error("position lookup outside change");
`endif

endmodule

### tb/sv/imq_checker.sv
// Checker for the indexed min priority queue: heap predictor and response scoreboard.
module imq_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [47:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [55:0] rsp_tdata,
   output int          fail_count,
   output int          pending_count,
   output int          extract_ok_count
);

   localparam int DEPTH = 16;

   typedef struct packed {
      logic [8:0]         count;
      logic               was_queued;
      logic signed [31:0] min_prio;
      logic [7:0]         min_key;
      logic [1:0]         status;
   } outcome_type;

   logic [7:0]         slot_key [256];
   logic [8:0]         key_slot [256];
   logic               key_live [256];
   logic signed [31:0] key_prio [256];
   int                 heap_size;
   outcome_type        expect_fifo [DEPTH];
   int                 wr_total = 0;
   int                 rd_total = 0;

   function automatic bit slot_lt(int a, int b);
      return key_prio[slot_key[a]] < key_prio[slot_key[b]];
   endfunction

   function automatic void swap_slots(int a, int b);
      logic [7:0] ka, kb;
      ka = slot_key[a];
      kb = slot_key[b];
      slot_key[a] = kb;
      slot_key[b] = ka;
      key_slot[kb] = 9'(a);
      key_slot[ka] = 9'(b);
   endfunction

   function automatic void bubble_up(int s);
      int p;
      while (s > 0) begin
         p = (s - 1) / 2;
         if (!slot_lt(s, p)) break;
         swap_slots(s, p);
         s = p;
      end
   endfunction

   function automatic void bubble_down(int s);
      int l, c;
      forever begin
         l = 2 * s + 1;
         if (l >= heap_size) break;
         c = l;
         if (l + 1 < heap_size && slot_lt(l + 1, l)) c = l + 1;
         if (!slot_lt(c, s)) break;
         swap_slots(c, s);
         s = c;
      end
   endfunction

   function automatic outcome_type apply_request(logic [1:0] op, logic [7:0] key,
                                                 logic signed [31:0] prio);
      outcome_type o;
      int s;
      logic [7:0] top;
      o = '0;
      o.was_queued = key_live[key];
      if (op == imq_pkg::OP_INSERT) begin
         if (key_live[key]) begin
            o.status = imq_pkg::ST_QUEUED;
         end else begin
            s = heap_size;
            key_prio[key] = prio;
            slot_key[s] = key;
            key_slot[key] = 9'(s);
            key_live[key] = 1'b1;
            heap_size = s + 1;
            bubble_up(s);
         end
      end else if (op == imq_pkg::OP_CHANGE) begin
         if (!key_live[key]) begin
            o.status = imq_pkg::ST_ABSENT;
         end else begin
            s = int'(key_slot[key]);
            if (prio > key_prio[key]) begin
               key_prio[key] = prio;
               bubble_down(s);
            end else begin
               key_prio[key] = prio;
               bubble_up(s);
            end
         end
      end else if (op == imq_pkg::OP_EXTRACT) begin
         if (heap_size == 0) begin
            o.status = imq_pkg::ST_EMPTY;
         end else begin
            top = slot_key[0];
            o.min_key = top;
            o.min_prio = key_prio[top];
            slot_key[0] = slot_key[heap_size - 1];
            key_slot[slot_key[0]] = 9'd0;
            key_live[top] = 1'b0;
            heap_size = heap_size - 1;
            if (heap_size > 0) bubble_down(0);
         end
      end
      o.count = 9'(heap_size);
      return o;
   endfunction

   assign pending_count = wr_total - rd_total;

   always @(posedge clock) begin
      outcome_type got, want, fresh;
      if (reset) begin
         for (int i = 0; i < 256; i++) key_live[i] = 1'b0;
         heap_size = 0;
         wr_total = 0;
         rd_total = 0;
         fail_count <= 0;
         extract_ok_count <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            fresh = apply_request(req_tdata[1:0], req_tdata[9:2], req_tdata[41:10]);
            if (req_tdata[1:0] == imq_pkg::OP_EXTRACT && fresh.status == imq_pkg::ST_OK)
               extract_ok_count <= extract_ok_count + 1;
            if (wr_total - rd_total >= DEPTH) begin
               $display("%0t: too many responses outstanding, expected at most %0d, actual %0d",
                        $time, DEPTH, wr_total - rd_total + 1);
               fail_count <= fail_count + 1;
            end else begin
               expect_fifo[wr_total % DEPTH] = fresh;
               wr_total = wr_total + 1;
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[51:0];
            if (wr_total == rd_total) begin
               $display("%0t: response beat, expected none, actual %h", $time, got);
               fail_count <= fail_count + 1;
            end else begin
               want = expect_fifo[rd_total % DEPTH];
               rd_total = rd_total + 1;
               if (want !== got || rsp_tdata[55:52] !== 4'd0) begin
                  $display("%0t: mismatch expected st=%0d key=%0d prio=%0d was=%0d cnt=%0d",
                           $time, want.status, want.min_key, want.min_prio,
                           want.was_queued, want.count);
                  $display("%0t:          actual st=%0d key=%0d prio=%0d was=%0d cnt=%0d",
                           $time, got.status, got.min_key, got.min_prio,
                           got.was_queued, got.count);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

### tb/sv/tb_indexed_min_priority_queue.sv
// Testbench top: drives heap requests and response back-pressure, reports the verdict.
module tb_indexed_min_priority_queue;

   localparam int WATCHDOG = 20000;
   localparam int RANDOM_ITEMS = 1500;
   localparam int LONG_HOLD_AT = 320;
   localparam int LONG_HOLD = 400;
   localparam logic [1:0] OP_UNDEFINED = 2'd3;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;
   int          fail_count, pending_count, extract_ok_count;
   int          idle_count = 0;
   bit          calm = 1'b0;
   int          sent = 0;

   always #1 clock = ~clock;

   indexed_min_priority_queue dut (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata,
      .rsp_tvalid, .rsp_tready, .rsp_tdata
   );

   imq_checker scoreboard (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata,
      .rsp_tvalid, .rsp_tready, .rsp_tdata,
      .fail_count, .pending_count, .extract_ok_count
   );

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_count <= 0;
      else
         idle_count <= idle_count + 1;
      if (idle_count >= WATCHDOG) begin
         $display("watchdog expired after %0d idle cycles", idle_count);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // receiver: random stall bursts, one long hold-off, none near the end
   initial begin
      int n;
      bit long_done;
      long_done = 1'b0;
      @(posedge clock iff !reset);
      forever begin
         if (!long_done && sent >= LONG_HOLD_AT) begin
            long_done = 1'b1;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else if (!calm && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 17);
            rsp_tready <= 1'b0;
            repeat (n) @(posedge clock);
         end else begin
            n = $urandom_range(1, 30);
            rsp_tready <= 1'b1;
            repeat (n) @(posedge clock);
         end
      end
   end

   task automatic send_beat(logic [1:0] op, logic [7:0] key, logic [31:0] prio);
      int n;
      if (!calm && $urandom_range(0, 3) == 0) begin
         n = $urandom_range(1, 17);
         req_tvalid <= 1'b0;
         repeat (n) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {6'd0, prio, key, op};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent++;
   endtask

   function automatic logic [31:0] pick_prio();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return $urandom_range(0, 7) << 16;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [1:0] pick_op(int fill);
      int r;
      r = $urandom_range(0, 99);
      if (r < 2) return OP_UNDEFINED;
      if (fill < 40)
         return r < 60 ? imq_pkg::OP_INSERT
                       : (r < 82 ? imq_pkg::OP_CHANGE : imq_pkg::OP_EXTRACT);
      return r < 35 ? imq_pkg::OP_INSERT
                    : (r < 60 ? imq_pkg::OP_CHANGE : imq_pkg::OP_EXTRACT);
   endfunction

   initial begin
      int fill;
      logic [1:0] op;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed corner cases
      send_beat(imq_pkg::OP_EXTRACT, 8'd0, 32'd0);
      send_beat(imq_pkg::OP_CHANGE, 8'd9, 32'd5);
      send_beat(imq_pkg::OP_INSERT, 8'd0, 32'h7fff_ffff);
      send_beat(imq_pkg::OP_INSERT, 8'd0, 32'd1);
      send_beat(imq_pkg::OP_INSERT, 8'd255, 32'h8000_0000);
      send_beat(imq_pkg::OP_INSERT, 8'd7, 32'h0001_0000);
      send_beat(imq_pkg::OP_INSERT, 8'd8, 32'h0001_0000);
      send_beat(imq_pkg::OP_INSERT, 8'd9, 32'h0001_0000);
      send_beat(imq_pkg::OP_INSERT, 8'd10, 32'hffff_0000);
      send_beat(imq_pkg::OP_CHANGE, 8'd255, 32'h7fff_fffe);
      send_beat(imq_pkg::OP_CHANGE, 8'd0, 32'h8000_0000);
      send_beat(imq_pkg::OP_CHANGE, 8'd7, 32'h0001_0000);
      send_beat(OP_UNDEFINED, 8'haa, 32'h5555_aaaa);
      send_beat(OP_UNDEFINED, 8'h55, 32'haaaa_5555);
      repeat (8) send_beat(imq_pkg::OP_EXTRACT, 8'd0, 32'd0);
      fill = 0;
      // random mix; the long hold-off lands early so requests back up
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == RANDOM_ITEMS - 200) calm = 1'b1;
         op = pick_op(fill);
         send_beat(op, $urandom_range(0, 9) < 7 ? 8'($urandom_range(0, 63))
                                                : 8'($urandom_range(0, 255)),
                   pick_prio());
         if (op == imq_pkg::OP_INSERT) fill++;
         else if (op == imq_pkg::OP_EXTRACT && fill > 0) fill--;
      end
      // drain the heap fully
      repeat (260) send_beat(imq_pkg::OP_EXTRACT, 8'($urandom), $urandom);
      req_tvalid <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      $display("sent %0d request beats of insert, change, extract and undefined opcodes,",
               sent);
      $display("with %0d successful extracts, empty, duplicate, absent and full-drain cases",
               extract_ok_count);
      if (fail_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
